// ===== rtl/kmw_pkg.sv =====
package kmw_pkg;

    localparam int MAX_CELLS_DEF = 1024;
    localparam int MAX_SIDE_DEF  = 32;

    localparam int CELL_IDX_W = 10;
    localparam int SIDE_CFG_W = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 6'd32;

    localparam logic OP_WALL    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic DIR_RIGHT = 1'b0;
    localparam logic DIR_DOWN  = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    typedef struct packed {
        logic                  op;
        logic [CELL_IDX_W-1:0] cell_index;
        logic                  wall_dir;
    } in_item_t;

    typedef struct packed {
        logic                  removed;
        logic [CELL_IDX_W-1:0] neighbor_index;
        logic                  status;
    } out_item_t;

endpackage

// ===== rtl/kruskal_maze_wall_merger.sv =====
// Kruskal maze wall merger.
// Input channel (in_valid / in_stall / in_item): one item per wall offer or restart.
// Output channel (out_valid / out_stall / out_item): exactly one result item per input item.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): grid width (index 0)
// and grid height (index 1); write only while the block is idle.
// One item is in flight at a time; in_stall stays high until its result is taken.
// Wall offer: the result follows a bounds check, a 10-step restoring divider (column check
// for a right wall, row check for a down wall), the edge check and the two root walks; the
// single read port of the parent memory is used for both root walks.
// A wall failing the bounds check answers straight from S_CHECK, one failing the edge check
// from S_JUDGE. A taken result returns the block to S_IDLE before the next item is accepted.
// Restart: the result is valid after a clearing pass that rewrites one parent entry per
// cycle.
// Reset: registers return to 32 x 32 and a clearing pass rewrites every parent link and
// opening; in_stall is high during it, config is still taken.
// A stalled result holds on out_item until out_stall drops; no new item enters meanwhile.
module kruskal_maze_wall_merger #(
    parameter int MAX_CELLS = kmw_pkg::MAX_CELLS_DEF,
    parameter int MAX_SIDE  = kmw_pkg::MAX_SIDE_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  kmw_pkg::in_item_t                         in_item,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output kmw_pkg::out_item_t                        out_item,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [kmw_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [kmw_pkg::SIDE_CFG_W-1:0]            cfg_data
);

    import kmw_pkg::*;

    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int NB_W      = CELL_IDX_W + 1;
    localparam int AREA_W    = 2 * SIDE_CFG_W;
    localparam int DIV_STEPS = CELL_IDX_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(MAX_CELLS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_JUDGE  = 4'd4;
    localparam logic [3:0] S_FIND_A = 4'd5;
    localparam logic [3:0] S_WALK_A = 4'd6;
    localparam logic [3:0] S_FIND_B = 4'd7;
    localparam logic [3:0] S_WALK_B = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [CELL_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                  clr_reply_reg, clr_reply_next;
    logic [SIDE_CFG_W-1:0] width_reg, width_next;
    logic [SIDE_CFG_W-1:0] height_reg, height_next;
    logic [DCNT_W-1:0]     div_cnt_reg, div_cnt_next;

    logic [CELL_IDX_W-1:0] cell_reg, cell_next;
    logic                  dir_reg, dir_next;
    logic [NB_W-1:0]       nb_reg, nb_next;
    logic [SIDE_CFG_W-1:0] w_eff_reg, w_eff_next;
    logic [SIDE_CFG_W-1:0] h_eff_reg, h_eff_next;
    logic [SIDE_CFG_W-1:0] rem_reg, rem_next;
    logic [CELL_IDX_W-1:0] quo_reg, quo_next;
    logic [CELL_W-1:0]     cur_reg, cur_next;
    logic [CELL_W-1:0]     root_a_reg, root_a_next;
    out_item_t             out_reg, out_next;

    logic [SIDE_CFG_W-1:0] w_clamp, h_clamp;
    logic [AREA_W-1:0]     area;
    logic                  inside_ok;
    logic [SIDE_CFG_W:0]   div_shift;
    logic                  div_ge;
    logic                  judge_ok;
    logic                  joined;

    logic                  par_we;
    logic [CELL_W-1:0]     par_waddr, par_wdata, par_raddr, par_rdata;
    logic                  right_we, down_we, open_bit;
    logic [CELL_W-1:0]     open_addr;

    kmw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_CELLS)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (par_we),
        .wr_addr (par_waddr),
        .wr_data (par_wdata),
        .rd_addr (par_raddr),
        .rd_data (par_rdata)
    );

    kmw_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS)
    ) u_right_ram (
        .clk     (clk),
        .wr_en   (right_we),
        .wr_addr (open_addr),
        .wr_data (open_bit),
        .rd_addr (open_addr),
        .rd_data ()
    );

    kmw_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS)
    ) u_down_ram (
        .clk     (clk),
        .wr_en   (down_we),
        .wr_addr (open_addr),
        .wr_data (open_bit),
        .rd_addr (open_addr),
        .rd_data ()
    );

    assign w_clamp = (32'(width_reg) > 32'(MAX_SIDE)) ? SIDE_CFG_W'(MAX_SIDE) : width_reg;
    assign h_clamp = (32'(height_reg) > 32'(MAX_SIDE)) ? SIDE_CFG_W'(MAX_SIDE) : height_reg;

    assign area      = AREA_W'(w_eff_reg) * AREA_W'(h_eff_reg);
    assign inside_ok = (w_eff_reg != '0) && (h_eff_reg != '0)
                    && (AREA_W'(cell_reg) < area)
                    && (32'(cell_reg) < 32'(MAX_CELLS))
                    && (32'(nb_reg) < 32'(MAX_CELLS));

    // restoring divide step: remainder and quotient of cell / width
    assign div_shift = {rem_reg, quo_reg[CELL_IDX_W-1]};
    assign div_ge    = (div_shift >= {1'b0, w_eff_reg});
    assign judge_ok  = (dir_reg == DIR_RIGHT) ? (rem_reg != (w_eff_reg - 1'b1))
                     : (quo_reg < (CELL_IDX_W'(h_eff_reg) - 1'b1));

    assign joined = (par_rdata == cur_reg);

    always_comb
    begin
        par_raddr = cur_reg;
        if (state_reg inside {S_WALK_A, S_WALK_B})
        begin
            par_raddr = par_rdata;
        end
    end

    always_comb
    begin
        par_we    = 1'b0;
        par_waddr = root_a_reg;
        par_wdata = cur_reg;
        right_we  = 1'b0;
        down_we   = 1'b0;
        open_bit  = 1'b1;
        open_addr = CELL_W'(cell_reg);
        if (state_reg == S_CLEAR)
        begin
            par_we    = 1'b1;
            par_waddr = clr_cnt_reg;
            par_wdata = clr_cnt_reg;
            right_we  = 1'b1;
            down_we   = 1'b1;
            open_bit  = 1'b0;
            open_addr = clr_cnt_reg;
        end
        else if ((state_reg == S_WALK_B) && joined && (root_a_reg != cur_reg))
        begin
            par_we   = 1'b1;
            right_we = (dir_reg == DIR_RIGHT);
            down_we  = (dir_reg == DIR_DOWN);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        div_cnt_next   = div_cnt_reg;
        cell_next      = cell_reg;
        dir_next       = dir_reg;
        nb_next        = nb_reg;
        w_eff_next     = w_eff_reg;
        h_eff_next     = h_eff_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cur_next       = cur_reg;
        root_a_next    = root_a_reg;
        out_next       = out_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  width_next  = cfg_data;
                CFG_GRID_HEIGHT: height_next = cfg_data;
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cell_next  = in_item.cell_index;
                    dir_next   = in_item.wall_dir;
                    w_eff_next = w_clamp;
                    h_eff_next = h_clamp;
                    nb_next    = NB_W'(in_item.cell_index)
                               + ((in_item.wall_dir == DIR_RIGHT) ? NB_W'(1)
                                                                  : NB_W'(w_clamp));
                    if (in_item.op == OP_RESTART)
                    begin
                        out_next       = '{removed: 1'b0, neighbor_index: '0,
                                           status: STATUS_OK};
                        clr_reply_next = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_CELL)
                begin
                    clr_cnt_next   = '0;
                    clr_reply_next = 1'b0;
                    state_next     = clr_reply_reg ? S_OUT : S_IDLE;
                end
            end
            S_CHECK:
            begin
                out_next = '{removed: 1'b0, neighbor_index: nb_reg[CELL_IDX_W-1:0],
                             status: STATUS_OUTSIDE};
                rem_next     = '0;
                quo_next     = cell_reg;
                div_cnt_next = '0;
                state_next   = inside_ok ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                rem_next     = SIDE_CFG_W'(div_ge ? (div_shift - {1'b0, w_eff_reg})
                                                  : div_shift);
                quo_next     = {quo_reg[CELL_IDX_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                cur_next   = CELL_W'(cell_reg);
                state_next = judge_ok ? S_FIND_A : S_OUT;
            end
            S_FIND_A:
            begin
                state_next = S_WALK_A;
            end
            S_WALK_A:
            begin
                if (joined)
                begin
                    root_a_next = cur_reg;
                    cur_next    = CELL_W'(nb_reg);
                    state_next  = S_FIND_B;
                end
                else
                begin
                    cur_next = par_rdata;
                end
            end
            S_FIND_B:
            begin
                state_next = S_WALK_B;
            end
            S_WALK_B:
            begin
                if (joined)
                begin
                    out_next.status  = STATUS_OK;
                    out_next.removed = (root_a_reg != cur_reg);
                    state_next       = S_OUT;
                end
                else
                begin
                    cur_next = par_rdata;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            width_reg     <= SIDE_RESET;
            height_reg    <= SIDE_RESET;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg   <= cell_next;
        dir_reg    <= dir_next;
        nb_reg     <= nb_next;
        w_eff_reg  <= w_eff_next;
        h_eff_reg  <= h_eff_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cur_reg    <= cur_next;
        root_a_reg <= root_a_next;
        out_reg    <= out_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_item  = out_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    a_no_same_cycle_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result shown in the cycle after acceptance");

    a_removed_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.removed) |-> (out_item.status == STATUS_OK))
        else $error("removed wall reported as outside the grid");

    a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (par_we && (state_reg != S_CLEAR)) |-> (root_a_reg != cur_reg))
        else $error("merge of a set with itself");
`endif

endmodule

// ===== rtl/kmw_ram.sv =====
module kmw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_q_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import kmw_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 160;

    class wall_merge_tracker;
        logic [CELL_IDX_W-1:0] parent_of [MAX_CELLS_DEF];
        bit                    right_open [MAX_CELLS_DEF];
        bit                    down_open [MAX_CELLS_DEF];
        logic [SIDE_CFG_W-1:0] grid_w;
        logic [SIDE_CFG_W-1:0] grid_h;
        out_item_t             verdicts_due [$];
        int unsigned           failures;

        function new();
            grid_w   = SIDE_RESET;
            grid_h   = SIDE_RESET;
            failures = 0;
            clear_maze();
        endfunction

        function void clear_maze();
            for (int i = 0; i < MAX_CELLS_DEF; i++)
            begin
                parent_of[i]  = CELL_IDX_W'(i);
                right_open[i] = 1'b0;
                down_open[i]  = 1'b0;
            end
        endfunction

        // bounded walk so a corrupt chain cannot hang the predictor
        function int unsigned find_set_root(int unsigned c);
            int unsigned steps;
            steps = 0;
            while (parent_of[c] != c && steps < MAX_CELLS_DEF)
            begin
                c = parent_of[c];
                steps++;
            end
            return c;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_CFG_W-1:0] val);
            if (idx == CFG_GRID_WIDTH)
                grid_w = val;
            else if (idx == CFG_GRID_HEIGHT)
                grid_h = val;
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction

        function void log_offer(in_item_t it);
            int unsigned w;
            int unsigned h;
            int unsigned cell_no;
            int unsigned nb;
            int unsigned ra;
            int unsigned rb;
            bit          ok;
            out_item_t   v;
            v = '0;
            if (it.op == OP_RESTART)
            begin
                clear_maze();
            end
            else
            begin
                w       = (grid_w > MAX_SIDE_DEF) ? MAX_SIDE_DEF : grid_w;
                h       = (grid_h > MAX_SIDE_DEF) ? MAX_SIDE_DEF : grid_h;
                cell_no = it.cell_index;
                nb      = (it.wall_dir == DIR_RIGHT) ? cell_no + 1 : cell_no + w;
                v.neighbor_index = nb[CELL_IDX_W-1:0];
                ok = (w != 0) && (h != 0) && (cell_no < w * h) &&
                     (cell_no < MAX_CELLS_DEF) && (nb < MAX_CELLS_DEF);
                if (ok)
                begin
                    if (it.wall_dir == DIR_RIGHT)
                        ok = (cell_no % w) != w - 1;
                    else
                        ok = (cell_no / w) < h - 1;
                end
                if (!ok)
                begin
                    v.status = STATUS_OUTSIDE;
                end
                else
                begin
                    v.status = STATUS_OK;
                    ra = find_set_root(cell_no);
                    rb = find_set_root(nb);
                    if (ra != rb)
                    begin
                        if (it.wall_dir == DIR_RIGHT)
                            right_open[cell_no] = 1'b1;
                        else
                            down_open[cell_no] = 1'b1;
                        parent_of[ra] = CELL_IDX_W'(rb);
                        v.removed = 1'b1;
                    end
                end
            end
            verdicts_due = {verdicts_due, v};
        endfunction

        function void check_verdict(out_item_t got);
            out_item_t want;
            if (verdicts_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with none due: removed %0d nb %0d status %0d",
                             $realtime, got.removed, got.neighbor_index, got.status);
                return;
            end
            want = verdicts_due.pop_front();
            if (got.removed !== want.removed || got.neighbor_index !== want.neighbor_index ||
                got.status !== want.status)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch exp removed %0d nb %0d status %0d, got %0d %0d %0d",
                             $realtime, want.removed, want.neighbor_index, want.status,
                             got.removed, got.neighbor_index, got.status);
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SIDE_CFG_W-1:0] cfg_data  = '0;

    wall_merge_tracker tracker;

    int unsigned gap_pct       = 23;
    int unsigned stall_pct     = 45;
    int unsigned results_taken = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    int unsigned quiet_cycles  = 0;

    wire in_acc  = in_valid && !in_stall;
    wire out_acc = out_valid && !out_stall;
    wire cfg_acc = cfg_valid && cfg_ready;

    kruskal_maze_wall_merger u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_acc)
                tracker.check_verdict(out_item);
            if (cfg_acc)
                tracker.write_reg(cfg_index, cfg_data);
            if (in_acc)
                tracker.log_offer(in_item);
        end
    end

    // result side; one long hold-off fills the block and backs up the input
    always @(posedge clk)
    begin
        if (out_acc)
            results_taken++;
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_taken >= 300)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (in_acc || out_acc || cfg_acc)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(input logic op, input logic [CELL_IDX_W-1:0] cell_no,
                             input logic dir);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{op: op, cell_index: cell_no, wall_dir: dir};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // only while nothing is in flight
    task automatic set_grid(input logic [SIDE_CFG_W-1:0] w, input logic [SIDE_CFG_W-1:0] h);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        put_reg(CFG_GRID_WIDTH, w);
        put_reg(CFG_GRID_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    logic [SIDE_CFG_W-1:0] seg_w [SEGMENTS] = '{6'd4, 6'd1, 6'd32, 6'd2, 6'd63, 6'd7,
                                                 6'd32, 6'd3, 6'd5, 6'd16, 6'd1, 6'd6};
    logic [SIDE_CFG_W-1:0] seg_h [SEGMENTS] = '{6'd4, 6'd1, 6'd32, 6'd3, 6'd63, 6'd5,
                                                 6'd1, 6'd3, 6'd40, 6'd16, 6'd32, 6'd9};

    initial
    begin
        int unsigned we;
        int unsigned he;
        int unsigned roll;
        tracker = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // default 32 x 32 grid
        send_item(OP_WALL, 10'd0, DIR_RIGHT);
        send_item(OP_WALL, 10'd0, DIR_RIGHT);
        send_item(OP_WALL, 10'd0, DIR_DOWN);
        send_item(OP_WALL, 10'd1, DIR_DOWN);
        send_item(OP_WALL, 10'd32, DIR_RIGHT);
        send_item(OP_WALL, 10'd31, DIR_RIGHT);
        send_item(OP_WALL, 10'd992, DIR_DOWN);
        send_item(OP_WALL, 10'd1023, DIR_RIGHT);
        send_item(OP_WALL, 10'd1023, DIR_DOWN);
        send_item(OP_WALL, 10'd1022, DIR_RIGHT);
        send_item(OP_RESTART, 10'd1023, DIR_DOWN);
        send_item(OP_WALL, 10'd0, DIR_RIGHT);

        set_grid(6'd0, 6'd32);
        send_item(OP_WALL, 10'd0, DIR_RIGHT);
        set_grid(6'd63, 6'd1);
        send_item(OP_WALL, 10'd5, DIR_RIGHT);
        send_item(OP_WALL, 10'd5, DIR_DOWN);
        send_item(OP_WALL, 10'd40, DIR_RIGHT);
        set_grid(6'd1, 6'd32);
        send_item(OP_WALL, 10'd3, DIR_RIGHT);
        send_item(OP_WALL, 10'd3, DIR_DOWN);
        set_grid(6'd1, 6'd0);
        send_item(OP_WALL, 10'd0, DIR_DOWN);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 4)
            begin
                gap_pct   = 45;
                stall_pct = 23;
            end
            if (seg == 8)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            set_grid(seg_w[seg], seg_h[seg]);
            we = (seg_w[seg] > MAX_SIDE_DEF) ? MAX_SIDE_DEF : seg_w[seg];
            he = (seg_h[seg] > MAX_SIDE_DEF) ? MAX_SIDE_DEF : seg_h[seg];
            send_item(OP_RESTART, CELL_IDX_W'($urandom), 1'($urandom));
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    send_item(OP_RESTART, CELL_IDX_W'($urandom), 1'($urandom));
                else if (roll < 85 && we * he != 0)
                    send_item(OP_WALL, CELL_IDX_W'($urandom_range(we * he - 1)),
                              1'($urandom));
                else
                    send_item(OP_WALL, CELL_IDX_W'($urandom), 1'($urandom));
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (100) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
